### design/lsoc_pkg.sv
// Shared types and constants for the line segment overlap counter.
package lsoc_pkg;

  localparam int GRID_SIDE  = 1024;
  localparam int GRID_DEPTH = GRID_SIDE * GRID_SIDE;
  localparam int ADDR_W     = $clog2(GRID_DEPTH);
  localparam int COORD_W    = 10;
  localparam int COUNT_W    = 21;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic {
    ACT_DRAW  = 1'b0,
    ACT_CLEAR = 1'b1
  } action_e;

  typedef struct packed {
    logic               action;
    logic [COORD_W-1:0] x_start;
    logic [COORD_W-1:0] y_start;
    logic [COORD_W-1:0] x_end;
    logic [COORD_W-1:0] y_end;
  } in_item_t;

  typedef struct packed {
    logic [COUNT_W-1:0] overlap_count;
    logic               skipped;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_DRAW,
    ST_DRAIN,
    ST_RESULT
  } state_e;

  typedef struct packed {
    logic in_ready;
    logic mem_re;
    logic sweep_we;
    logic start_draw;
    logic start_clear;
    logic load_out;
  } ctrl_t;

endpackage

### design/line_segment_overlap_counter_unit.sv
// Line segment rasterizer with a coverage grid memory and a running overlap count.
// A drawn segment is walked cell by cell, one grid read-modify-write per cell pipelined
// through the single-port-write grid memory, then passes a drain state and a result state.
// A skipped segment goes from the check state straight to the result state; a clear request
// sweeps the grid one cell a cycle. One request at a time: the next is taken after the result.
// Reset sweeps the grid (no request taken); diag mode resets to 1.
module line_segment_overlap_counter_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  lsoc_pkg::in_item_t in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output lsoc_pkg::out_item_t out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               cfg_data_i
);
  import lsoc_pkg::*;

  localparam logic [ADDR_W-1:0] ROW_STEP   = ADDR_W'(GRID_SIDE);
  localparam logic [ADDR_W-1:0] SWEEP_LAST = ADDR_W'(GRID_DEPTH - 1);

  state_e state_q, state_d;
  ctrl_t  ctrl;

  in_item_t           item_q;
  logic               diag_en_q;
  logic [COUNT_W-1:0] count_q;
  logic               skip_q;
  logic               clear_item_q;
  logic [ADDR_W-1:0]  addr_q;
  logic [ADDR_W-1:0]  delta_q;
  logic [COORD_W-1:0] left_q;
  logic [ADDR_W-1:0]  sweep_q;
  logic               rd_vld_q;
  logic [ADDR_W-1:0]  wr_addr_q;
  logic [1:0]         rd_data_q;
  out_item_t          out_q;
  logic               out_valid_q;

  logic [1:0] grid_mem [GRID_DEPTH];

  // Segment classification, evaluated in the check state.
  logic [COORD_W-1:0] dx, dy, span_max;
  logic               off_grid, is_axis, is_diag, skip_seg;
  logic [ADDR_W-1:0]  start_addr, x_step, y_step;

  always_comb begin
    dx       = (item_q.x_start > item_q.x_end) ? item_q.x_start - item_q.x_end
                                               : item_q.x_end - item_q.x_start;
    dy       = (item_q.y_start > item_q.y_end) ? item_q.y_start - item_q.y_end
                                               : item_q.y_end - item_q.y_start;
    span_max = (dx > dy) ? dx : dy;
    off_grid = (32'(item_q.x_start) >= GRID_SIDE) || (32'(item_q.y_start) >= GRID_SIDE) ||
               (32'(item_q.x_end) >= GRID_SIDE) || (32'(item_q.y_end) >= GRID_SIDE);
    is_axis  = (dx == '0) || (dy == '0);
    is_diag  = (dx == dy) && (dx != '0);
    skip_seg = off_grid || (!is_axis && !(is_diag && diag_en_q));
    start_addr = ADDR_W'(32'(item_q.y_start) * GRID_SIDE + 32'(item_q.x_start));
    // Steps are kept modulo the address width, so a negative step is its complement.
    if (item_q.x_end > item_q.x_start) begin
      x_step = ADDR_W'(1);
    end else if (item_q.x_end < item_q.x_start) begin
      x_step = '1;
    end else begin
      x_step = '0;
    end
    if (item_q.y_end > item_q.y_start) begin
      y_step = ROW_STEP;
    end else if (item_q.y_end < item_q.y_start) begin
      y_step = ~ROW_STEP + ADDR_W'(1);
    end else begin
      y_step = '0;
    end
  end

  logic slot_free;
  assign slot_free = !out_valid_q || out_ready_i;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (sweep_q == SWEEP_LAST) begin
          state_d = clear_item_q ? ST_RESULT : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (item_q.action == ACT_CLEAR) begin
          state_d = ST_CLEAR;
        end else if (skip_seg) begin
          state_d = ST_RESULT;
        end else begin
          state_d = ST_DRAW;
        end
      end
      ST_DRAW: begin
        if (left_q == '0) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN:  state_d = ST_RESULT;
      ST_RESULT: begin
        if (slot_free) begin
          state_d = ST_IDLE;
        end
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    ctrl = '0;
    unique case (state_q)
      ST_CLEAR:  ctrl.sweep_we = 1'b1;
      ST_IDLE:   ctrl.in_ready = 1'b1;
      ST_CHECK: begin
        ctrl.start_clear = (item_q.action == ACT_CLEAR);
        ctrl.start_draw  = (item_q.action == ACT_DRAW) && !skip_seg;
      end
      ST_DRAW:   ctrl.mem_re   = 1'b1;
      ST_DRAIN:  ctrl = '0;
      ST_RESULT: ctrl.load_out = slot_free;
      default:   ctrl = '0;
    endcase
  end

  // Write-back half of the read-modify-write: the cell read last cycle is bumped now.
  logic              rmw_we, mem_we;
  logic [ADDR_W-1:0] mem_wa;
  logic [1:0]        mem_wd;

  assign rmw_we = rd_vld_q && (rd_data_q < 2'd2);
  assign mem_we = ctrl.sweep_we || rmw_we;
  assign mem_wa = ctrl.sweep_we ? sweep_q : wr_addr_q;
  assign mem_wd = ctrl.sweep_we ? 2'd0 : rd_data_q + 2'd1;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      grid_mem[mem_wa] <= mem_wd;
    end
    if (ctrl.mem_re) begin
      rd_data_q <= grid_mem[addr_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      diag_en_q    <= 1'b1;
      count_q      <= '0;
      skip_q       <= 1'b0;
      clear_item_q <= 1'b0;
      sweep_q      <= '0;
      rd_vld_q     <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= ctrl.mem_re;
      if (cfg_valid_i) begin
        diag_en_q <= cfg_data_i;
      end
      if (ctrl.sweep_we) begin
        sweep_q <= sweep_q + ADDR_W'(1);
      end
      if (ctrl.start_clear) begin
        count_q      <= '0;
        sweep_q      <= '0;
        clear_item_q <= 1'b1;
      end else if (rd_vld_q && (rd_data_q == 2'd1) && (count_q < COUNT_MAX)) begin
        count_q <= count_q + COUNT_W'(1);
      end
      if (state_q == ST_CHECK) begin
        skip_q <= (item_q.action == ACT_DRAW) && skip_seg;
      end
      if (ctrl.load_out) begin
        clear_item_q <= 1'b0;
        out_valid_q  <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && ctrl.in_ready) begin
      item_q <= in_data_i;
    end
    if (ctrl.start_draw) begin
      addr_q  <= start_addr;
      delta_q <= x_step + y_step;
      left_q  <= span_max;
    end else if (ctrl.mem_re) begin
      addr_q <= addr_q + delta_q;
      left_q <= left_q - COORD_W'(1);
    end
    if (ctrl.mem_re) begin
      wr_addr_q <= addr_q;
    end
    if (ctrl.load_out) begin
      out_q.overlap_count <= count_q;
      out_q.skipped       <= skip_q;
    end
  end

  assign in_ready_o  = ctrl.in_ready;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign cfg_ready_o = 1'b1;

  // A write-back only follows a read issued in the draw state.
  a_rd_from_draw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> $past(state_q) == ST_DRAW)
    else $error("grid read data valid without a draw read");

  // Consecutive cells of a segment differ, so a read never hits the cell being written.
  a_no_rw_collision: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rmw_we && ctrl.mem_re) |-> (wr_addr_q != addr_q))
    else $error("grid read and write at the same cell");

  // The last write-back lands before the result is formed.
  a_drain_writeback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DRAIN) |-> rd_vld_q)
    else $error("drain state without a pending write-back");

  // The overlap count holds at zero while the grid is being cleared.
  a_clear_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> (count_q == '0))
    else $error("overlap count nonzero during grid clear");

  // No request is taken while a segment is still being drawn.
  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> (!rd_vld_q && !ctrl.sweep_we))
    else $error("request accepted while grid work is pending");

endmodule

### test/line_segment_overlap_counter_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the line segment overlap counter unit.
module line_segment_overlap_counter_unit_tb;
  import lsoc_pkg::*;

  localparam int CLK_PERIOD    = 12;
  localparam int RESET_CYCLES  = 11;
  localparam int SETTLE_CYCLES = 1100;
  localparam int LONG_STALL    = 600;
  localparam int CYCLE_LIMIT   = 10_000_000;
  localparam int MAX_REPORTS   = 10;
  localparam int COORD_MAX     = (1 << COORD_W) - 1;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  in_item_t  in_data   = '0;
  logic      in_ready;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_data  = 1'b0;
  logic      cfg_ready;

  // Predictor state: sparse copy of the coverage grid, the count and the mode bit.
  logic [1:0]         cell_cover [int unsigned];
  logic [COUNT_W-1:0] overlap_total = '0;
  logic               diag_mode     = 1'b1;

  in_item_t  segment_queue[$];
  out_item_t expected_counts[$];
  out_item_t oldest;

  int     mismatch_count = 0;
  bit     in_taken       = 1'b0;
  int     gap_left       = 0;
  int     burst_left     = 0;
  int     stall_trigger  = 0;
  int     stall_seen     = 0;
  int     hold_left      = 0;
  int     pattern_left   = 0;
  int     ready_pct      = 100;
  longint cycle_count    = 0;

  line_segment_overlap_counter_unit i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic out_item_t rasterize_segment(in_item_t seg);
    out_item_t   res;
    int          x0, y0, x1, y1, dx, dy, sx, sy, n, x, y;
    int unsigned idx;
    logic [1:0]  c;
    x0 = seg.x_start;
    y0 = seg.y_start;
    x1 = seg.x_end;
    y1 = seg.y_end;
    res.skipped = 1'b0;
    if (seg.action == ACT_CLEAR) begin
      cell_cover.delete();
      overlap_total = '0;
    end else begin
      dx = (x0 > x1) ? x0 - x1 : x1 - x0;
      dy = (y0 > y1) ? y0 - y1 : y1 - y0;
      if (x0 >= GRID_SIDE || y0 >= GRID_SIDE || x1 >= GRID_SIDE || y1 >= GRID_SIDE) begin
        res.skipped = 1'b1;
      end else if (dx != 0 && dy != 0 && !(dx == dy && diag_mode)) begin
        res.skipped = 1'b1;
      end else begin
        sx = (x1 > x0) ? 1 : ((x1 < x0) ? -1 : 0);
        sy = (y1 > y0) ? 1 : ((y1 < y0) ? -1 : 0);
        n  = ((dx > dy) ? dx : dy) + 1;
        x  = x0;
        y  = y0;
        for (int i = 0; i < n; i++) begin
          idx = y * GRID_SIDE + x;
          c   = cell_cover.exists(idx) ? cell_cover[idx] : 2'd0;
          if (c < 2'd2) begin
            cell_cover[idx] = c + 2'd1;
            if (c == 2'd1 && overlap_total != COUNT_MAX) overlap_total++;
          end
          x += sx;
          y += sy;
        end
      end
    end
    res.overlap_count = overlap_total;
    return res;
  endfunction

  function automatic in_item_t line_item(int x0, int y0, int x1, int y1);
    in_item_t seg;
    seg.action  = ACT_DRAW;
    seg.x_start = COORD_W'(x0);
    seg.y_start = COORD_W'(y0);
    seg.x_end   = COORD_W'(x1);
    seg.y_end   = COORD_W'(y1);
    return seg;
  endfunction

  function automatic in_item_t random_segment();
    int wx, wy, x0, y0, len, sx, sy, kind;
    // Half the segments start inside one of a few small windows so that they overlap.
    if ($urandom_range(0, 1)) begin
      wx = $urandom_range(0, 3) * 320;
      wy = $urandom_range(0, 3) * 320;
      x0 = wx + $urandom_range(0, 63);
      y0 = wy + $urandom_range(0, 63);
    end else begin
      x0 = $urandom_range(0, COORD_MAX);
      y0 = $urandom_range(0, COORD_MAX);
    end
    len  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, COORD_MAX) : $urandom_range(0, 40);
    sx   = $urandom_range(0, 1) ? 1 : -1;
    sy   = $urandom_range(0, 1) ? 1 : -1;
    kind = $urandom_range(0, 99);
    if (kind < 35) begin
      sy = 0;
    end else if (kind < 60) begin
      sx = 0;
    end else if (kind < 85) begin
      // Diagonal: keep both directions.
    end else if (kind < 95) begin
      return line_item(x0, y0, $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX));
    end else begin
      sx = 0;
      sy = 0;
    end
    if (sx > 0 && len > COORD_MAX - x0) len = COORD_MAX - x0;
    if (sx < 0 && len > x0) len = x0;
    if (sy > 0 && len > COORD_MAX - y0) len = COORD_MAX - y0;
    if (sy < 0 && len > y0) len = y0;
    return line_item(x0, y0, x0 + sx * len, y0 + sy * len);
  endfunction

  task automatic report_mismatch(string what, out_item_t want, out_item_t got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("%0t: %s: expected count %0d skipped %0b, got count %0d skipped %0b",
               $time, what, want.overlap_count, want.skipped, got.overlap_count, got.skipped);
  endtask

  task automatic set_diag_mode(logic enable);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= enable;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    diag_mode = enable;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (segment_queue.size() != 0 || in_valid || expected_counts.size() != 0)
      @(negedge clk);
  endtask

  task automatic queue_random(int count);
    repeat (count) segment_queue.push_back(random_segment());
  endtask

  // Sender: bursts of requests separated by random gaps.
  always @(negedge clk) begin
    if (!in_valid || in_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (segment_queue.size() > 0) begin
        in_data  <= segment_queue.pop_front();
        in_valid <= 1'b1;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 16);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: stretches of varying readiness, plus a long hold when triggered.
  always @(negedge clk) begin
    if (stall_trigger != stall_seen) begin
      stall_seen = stall_trigger;
      hold_left  = LONG_STALL;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      if (pattern_left == 0) begin
        pattern_left = $urandom_range(16, 96);
        case ($urandom_range(0, 3))
          0: ready_pct = 100;
          1: ready_pct = 75;
          2: ready_pct = 40;
          default: ready_pct = 10;
        endcase
      end
      pattern_left--;
      out_ready <= ($urandom_range(0, 99) < ready_pct);
    end
  end

  always @(posedge clk) begin
    in_taken <= in_valid && in_ready;
    if (in_valid && in_ready) expected_counts.push_back(rasterize_segment(in_data));
    if (out_valid && out_ready) begin
      if (expected_counts.size() == 0) begin
        report_mismatch("result with no request outstanding", '0, out_data);
      end else begin
        oldest = expected_counts.pop_front();
        if (out_data.overlap_count !== oldest.overlap_count ||
            out_data.skipped !== oldest.skipped)
          report_mismatch("result differs", oldest, out_data);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    in_item_t wipe;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    set_diag_mode(1'b1);
    segment_queue.push_back(line_item(0, 0, 0, 0));
    segment_queue.push_back(line_item(0, 0, 0, 0));
    segment_queue.push_back(line_item(0, 0, COORD_MAX, 0));
    segment_queue.push_back(line_item(COORD_MAX, 0, 0, 0));
    segment_queue.push_back(line_item(COORD_MAX, COORD_MAX, COORD_MAX, 0));
    segment_queue.push_back(line_item(0, 0, 0, COORD_MAX));
    segment_queue.push_back(line_item(0, 0, COORD_MAX, COORD_MAX));
    segment_queue.push_back(line_item(COORD_MAX, 0, 0, COORD_MAX));
    segment_queue.push_back(line_item(10, 20, 5, 15));
    segment_queue.push_back(line_item(0, 0, COORD_MAX, COORD_MAX - 1));
    segment_queue.push_back(line_item(1, 0, 3, 1));
    segment_queue.push_back(line_item(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
    // The clear request ignores its coordinates.
    wipe        = line_item($urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                            $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX));
    wipe.action = ACT_CLEAR;
    segment_queue.push_back(wipe);
    segment_queue.push_back(line_item(5, 5, 5, 5));
    segment_queue.push_back(line_item(5, 5, 5, 5));
    wait_drained();

    // With diagonals disabled they are skipped while axis segments still draw.
    set_diag_mode(1'b0);
    segment_queue.push_back(line_item(0, 0, 9, 9));
    segment_queue.push_back(line_item(COORD_MAX, 0, COORD_MAX - 9, 9));
    segment_queue.push_back(line_item(3, 5, 0, 5));
    segment_queue.push_back(line_item(0, 5, 3, 5));
    segment_queue.push_back(line_item(2, 7, 9, 3));
    queue_random(100);
    wait_drained();
    queue_random(100);
    wait_drained();

    set_diag_mode(1'b1);
    stall_trigger++;
    queue_random(190);
    wait_drained();
    stall_trigger++;
    queue_random(190);
    wait_drained();

    repeat (SETTLE_CYCLES) @(negedge clk);
    mismatch_count += expected_counts.size();
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### files.f
design/lsoc_pkg.sv
design/line_segment_overlap_counter_unit.sv
test/line_segment_overlap_counter_unit_tb.sv
